FILE: hw/rtl/mcstb_pkg.sv
// Shared types and constants for the soft timer bank: command and result words,
// operation and result codes, slot sizing.
// No dependencies.
package mcstb_pkg;

  // Number of timer slots held in the bank.
  localparam int NUM_SLOTS = 8;
  // Most expire results one tick may report.
  localparam int MAX_RESULTS = 8;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);
  localparam int FSLOT_W = 3;
  localparam int PERIOD_W = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_START = 2'd1;
  localparam op_t OP_STOP = 2'd2;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_ACK = 2'd0;
  localparam kind_t KIND_FIRED = 2'd1;
  localparam kind_t KIND_NONE = 2'd2;

  typedef struct packed {
    op_t                 op;
    logic [FSLOT_W-1:0]  slot;
    logic [PERIOD_W-1:0] period;
    logic                one_shot;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [FSLOT_W-1:0] fired_slot;
    logic               last;
  } res_t;

endpackage

FILE: hw/rtl/multi_channel_soft_timer_bank_unit.sv
// Top level of the soft timer bank: slot table in two synchronous memories,
// scan sequencer and result register.
// Depends on mcstb_pkg.
//
//  port     dir  handshake              word
//  -------  ---  ---------------------  -----------------------------------
//  cmd      in   start high, busy low   op, slot, period, one_shot
//  result   out  strobe, one cycle      kind, fired_slot, last
//
// For start and stop the word is taken, the slot is written and the
// acknowledge appears on the cycle after. A tick holds busy through the
// scan: ST_SCAN makes one memory read per slot while the count memory port
// streams through the table, ST_FLUSH updates the last slot and ST_REPORT
// sends the closing result. Expire results appear during the scan, one
// behind the slot that caused them, so that the final one can carry last.
// Reset clears the active and mode flags but not the period and count
// memories; these are written on every start before a slot can go active,
// so they need no clearing pass. The receiver cannot stall the result side.
module multi_channel_soft_timer_bank_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  mcstb_pkg::cmd_t cmd,
  output logic            strobe,
  output mcstb_pkg::res_t result
);
  import mcstb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH, ST_REPORT} state_t;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

  state_t state;

  // Scan pointer (read side) and the slot whose read data is now valid.
  logic [SLOT_W-1:0] idx;
  logic [SLOT_W-1:0] proc_idx;
  logic              proc_vld;

  // One expire result held back until we know whether another follows.
  logic [SLOT_W-1:0]    pend_idx;
  logic                 pend_vld;
  logic [RES_CNT_W-1:0] n_rep;

  // Per-slot flags live in flip-flops so reset can clear them at once.
  logic [NUM_SLOTS-1:0] active;
  logic [NUM_SLOTS-1:0] single_mode;

  // Slot table: periods and running counts, one read per cycle each.
  logic [PERIOD_W-1:0] period_mem [NUM_SLOTS];
  logic [PERIOD_W-1:0] count_mem  [NUM_SLOTS];
  logic [PERIOD_W-1:0] per_q;
  logic [PERIOD_W-1:0] cnt_q;

  logic                accept;
  logic                slot_ok;
  logic [SLOT_W-1:0]   wslot;
  logic [PERIOD_W-1:0] cnt_inc;
  logic                slot_live;
  logic                fire;
  logic                report;

  assign busy    = (state != ST_IDLE);
  assign accept  = start && !busy;
  // Slots beyond the table are acknowledged but leave the state alone.
  assign slot_ok = (int'(cmd.slot) < NUM_SLOTS);
  assign wslot   = SLOT_W'(cmd.slot);

  // Read-modify-write of one slot per cycle. A running slot's count stays
  // below its period, or at zero for period zero: the increment cannot wrap.
  assign cnt_inc   = cnt_q + PERIOD_W'(1);
  assign slot_live = proc_vld && active[proc_idx];
  assign fire      = slot_live && (cnt_inc >= per_q);
  // Slots that fire past the result limit still reload but are not reported.
  assign report    = fire && (n_rep < RES_CNT_W'(MAX_RESULTS));

  // Period memory: written by start, read at the scan pointer.
  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_START) && slot_ok) begin
      period_mem[wslot] <= cmd.period;
    end
    per_q <= period_mem[idx];
  end

  // Count memory: cleared by start, advanced or reloaded by the scan. The
  // scan writes each slot once, in the cycle after reading it, and never
  // writes a slot whose read is still pending, so no forwarding is needed.
  always_ff @(posedge clk) begin
    if (accept && (cmd.op == OP_START) && slot_ok) begin
      count_mem[wslot] <= '0;
    end else if (slot_live) begin
      count_mem[proc_idx] <= fire ? '0 : cnt_inc;
    end
    cnt_q <= count_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      proc_idx    <= '0;
      proc_vld    <= 1'b0;
      pend_vld    <= 1'b0;
      n_rep       <= '0;
      active      <= '0;
      single_mode <= '0;
      strobe      <= 1'b0;
    end else begin
      strobe   <= 1'b0;
      proc_vld <= (state == ST_SCAN);
      proc_idx <= idx;

      // Drop a one-shot slot once it has fired.
      if (fire && single_mode[proc_idx]) begin
        active[proc_idx] <= 1'b0;
      end

      // Release the held result and hold the new one in its place.
      if (report) begin
        if (pend_vld) begin
          strobe <= 1'b1;
          result <= '{kind: KIND_FIRED, fired_slot: FSLOT_W'(pend_idx), last: 1'b0};
        end
        pend_idx <= proc_idx;
        pend_vld <= 1'b1;
        n_rep    <= n_rep + RES_CNT_W'(1);
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (cmd.op)
              OP_TICK: begin
                state    <= ST_SCAN;
                idx      <= '0;
                pend_vld <= 1'b0;
                n_rep    <= '0;
              end
              OP_START: begin
                if (slot_ok) begin
                  active[wslot]      <= 1'b1;
                  single_mode[wslot] <= cmd.one_shot;
                end
                strobe <= 1'b1;
                result <= '{kind: KIND_ACK, fired_slot: cmd.slot, last: 1'b1};
              end
              OP_STOP: begin
                if (slot_ok) begin
                  active[wslot] <= 1'b0;
                end
                strobe <= 1'b1;
                result <= '{kind: KIND_ACK, fired_slot: cmd.slot, last: 1'b1};
              end
              default: begin
                // Unused code: no state change, no result.
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (idx == LAST_SLOT) begin
            state <= ST_FLUSH;
          end else begin
            idx <= idx + SLOT_W'(1);
          end
        end
        ST_FLUSH: begin
          // The last slot is updated in this cycle.
          state <= ST_REPORT;
        end
        ST_REPORT: begin
          strobe <= 1'b1;
          if (pend_vld) begin
            result <= '{kind: KIND_FIRED, fired_slot: FSLOT_W'(pend_idx), last: 1'b1};
          end else begin
            result <= '{kind: KIND_NONE, fired_slot: '0, last: 1'b1};
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // An acknowledge only ever follows a taken start or stop word.
  a_ack_follows_cmd: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == KIND_ACK) |-> $past(accept))
    else $error("acknowledge without a start or stop word");

  // A none result closes its tick.
  a_none_is_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (result.kind == KIND_NONE) |-> result.last)
    else $error("none result not marked last");

  // The closing result of a tick frees the block on the next cycle.
  a_report_frees: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT) |=> !busy && strobe && result.last)
    else $error("tick did not close with a last result");

  // Never more results than the limit within one tick.
  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    n_rep <= RES_CNT_W'(MAX_RESULTS))
    else $error("expire result count over limit");

endmodule

FILE: verif/tb_multi_channel_soft_timer_bank_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the soft timer bank: sends start, stop and tick words,
// predicts every result word in a scoreboard class and checks each strobe against it.
// Depends on mcstb_pkg and multi_channel_soft_timer_bank_unit.
module tb_multi_channel_soft_timer_bank_unit;
  import mcstb_pkg::*;

  // The op code the bank must ignore: no state change, no result.
  localparam op_t OP_SPARE = 2'd3;

  // Mirror of the slot table plus the queue of result words still to come.
  class timer_bank_tracker;
    bit                running[NUM_SLOTS];
    bit                single[NUM_SLOTS];
    bit [PERIOD_W-1:0] alarm[NUM_SLOTS];
    bit [PERIOD_W-1:0] count[NUM_SLOTS];
    res_t              due[$];
    int                mismatches;

    task report_mismatch(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    // Apply one accepted command word to the mirror and queue what it causes.
    task note_word(cmd_t w);
      res_t r;
      int   n;
      int   i;
      n = 0;
      case (w.op)
        OP_START, OP_STOP: begin
          if (w.slot < NUM_SLOTS) begin
            if (w.op == OP_START) begin
              // Reload: a running slot is simply restarted from zero.
              alarm[w.slot]   = w.period;
              count[w.slot]   = '0;
              single[w.slot]  = w.one_shot;
              running[w.slot] = 1'b1;
            end else begin
              running[w.slot] = 1'b0;
            end
          end
          // Acknowledge even a stop of an idle slot.
          r.kind       = KIND_ACK;
          r.fired_slot = w.slot;
          r.last       = 1'b1;
          due.push_back(r);
        end
        OP_TICK: begin
          for (i = 0; i < NUM_SLOTS; i++) begin
            if (running[i]) begin
              count[i] = count[i] + 1'b1;
              // A period of zero passes this test on every tick.
              if (count[i] >= alarm[i]) begin
                count[i] = '0;
                if (single[i]) running[i] = 1'b0;
                if (n < MAX_RESULTS) begin
                  r.kind       = KIND_FIRED;
                  r.fired_slot = FSLOT_W'(i);
                  r.last       = 1'b0;
                  due.push_back(r);
                  n++;
                end
              end
            end
          end
          if (n == 0) begin
            r.kind       = KIND_NONE;
            r.fired_slot = '0;
            r.last       = 1'b1;
            due.push_back(r);
          end else begin
            // Mark the closing expire word.
            r      = due.pop_back();
            r.last = 1'b1;
            due.push_back(r);
          end
        end
        default: ;
      endcase
    endtask

    // Compare one result word with the oldest prediction, field by field.
    task match_result(res_t got);
      res_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d slot %0d last %0d",
                                  got.kind, got.fired_slot, got.last));
        return;
      end
      want = due.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, predicted %0d", got.kind, want.kind));
      if (got.fired_slot !== want.fired_slot)
        report_mismatch($sformatf("fired_slot %0d, predicted %0d",
                                  got.fired_slot, want.fired_slot));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %0d, predicted %0d", got.last, want.last));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic strobe;
  cmd_t cmd   = '0;
  res_t result;

  timer_bank_tracker tracker = new;
  int                sender_idle_pct;

  multi_channel_soft_timer_bank_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watch both sides at each edge: a word is taken when start is high and
  // busy is low; a result word is on the ports for the one strobed cycle.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) tracker.note_word(cmd);
      if (strobe) tracker.match_result(result);
    end
  end

  function automatic cmd_t word_of(op_t op, int slot, logic [PERIOD_W-1:0] period,
                                   logic one_shot);
    cmd_t w;
    w.op       = op;
    w.slot     = FSLOT_W'(slot);
    w.period   = period;
    w.one_shot = one_shot;
    return w;
  endfunction

  // Mostly short periods so that slots fire often; now and then a wide one
  // so every period bit toggles.
  function automatic logic [PERIOD_W-1:0] pick_period();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return $urandom_range(0, 4);
      6, 7:             return $urandom_range(5, 12);
      8:                return $urandom;
      default:          return 32'hFFFF_FFFF - $urandom_range(0, 3);
    endcase
  endfunction

  function automatic cmd_t random_word();
    int   pick;
    op_t  op;
    pick = $urandom_range(0, 99);
    if (pick < 45)      op = OP_TICK;
    else if (pick < 80) op = OP_START;
    else if (pick < 94) op = OP_STOP;
    else                op = OP_SPARE;
    return word_of(op, $urandom_range(0, 7), pick_period(), 1'($urandom_range(0, 1)));
  endfunction

  // Offer one word, idling cycle by cycle at the current rate; return at the
  // edge that takes it, with start still high so the next word can follow at once.
  task automatic send_word(cmd_t w);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= w;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    int idle_rate[3];
    int phase;
    int sent;
    cmd_t w;
    idle_rate[0] = 25;
    idle_rate[1] = 63;
    idle_rate[2] = 0;
    sender_idle_pct = idle_rate[0];

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words. Tick on an empty bank: a lone none word.
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    // Stop of a slot that is not running: acknowledged, nothing changes.
    send_word(word_of(OP_STOP, 5, 0, 1'b0));
    // Period zero fires on every tick.
    send_word(word_of(OP_START, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    send_word(word_of(OP_START, 7, 32'hFFFF_FFFF, 1'b1));
    send_word(word_of(OP_START, 1, 2, 1'b1));
    send_word(word_of(OP_TICK, 7, 32'hFFFF_FFFF, 1'b1));
    // Slot 1 fires once alongside slot 0, then drops out.
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    // The spare op code with every field at its top value: ignored.
    send_word(word_of(OP_SPARE, 7, 32'hFFFF_FFFF, 1'b1));
    // Restart of a running slot reloads it.
    send_word(word_of(OP_START, 0, 3, 1'b0));
    send_word(word_of(OP_STOP, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    // Fill every slot so one tick reports the most expire words.
    send_word(word_of(OP_START, 1, 1, 1'b1));
    send_word(word_of(OP_START, 2, 1, 1'b0));
    send_word(word_of(OP_START, 3, 1, 1'b1));
    send_word(word_of(OP_START, 4, 1, 1'b0));
    send_word(word_of(OP_START, 5, 1, 1'b1));
    send_word(word_of(OP_START, 6, 1, 1'b0));
    send_word(word_of(OP_START, 0, 0, 1'b0));
    send_word(word_of(OP_START, 7, 0, 1'b1));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));
    send_word(word_of(OP_STOP, 6, 0, 1'b0));
    send_word(word_of(OP_TICK, 0, 0, 1'b0));

    // Random words in three idling phases; ignored words do not count.
    for (phase = 0; phase < 3; phase++) begin
      sender_idle_pct = idle_rate[phase];
      sent = 0;
      while (sent < 32) begin
        w = random_word();
        send_word(w);
        if (w.op != OP_SPARE) sent++;
      end
    end
    start <= 1'b0;

    // Drain, then keep watching the result side to show any stray word.
    while (tracker.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.due.size() != 0)
      tracker.report_mismatch($sformatf("%0d predicted words never arrived",
                                        tracker.due.size()));

    if (tracker.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hold a hard ceiling well above the slowest legal run.
  initial begin
    #200000;
    $display("status: fail");
    $finish;
  end

endmodule
